/* rtl/core/assert_macros.svh */
// Assertion macros used by the checker file pcbez_chk.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, held off during reset.
`define AST_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, held off during reset.
`define AST_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* rtl/core/pcbez_pkg.sv */
// Types and constants of the Bezier curve evaluator.
// Used by every module of the block.
package pcbez_pkg;

    typedef struct packed {
        logic [1:0]         kind;
        logic [16:0]        param_u;
        logic signed [31:0] coord_a;
        logic signed [31:0] coord_b;
        logic signed [31:0] coord_c;
        logic signed [31:0] coord_d;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] value_a;
        logic signed [31:0] value_b;
        logic signed [31:0] value_c;
        logic signed [31:0] value_d;
        logic [1:0]         status;
    } out_item_t;

    localparam logic [1:0] KIND_APPEND  = 2'd0;
    localparam logic [1:0] KIND_CLEAR   = 2'd1;
    localparam logic [1:0] KIND_POINT   = 2'd2;
    localparam logic [1:0] KIND_TANGENT = 2'd3;

    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_INCOMPLETE = 2'd1;
    localparam logic [1:0] ST_FULL       = 2'd2;

    localparam logic [16:0] ONE_Q16 = 17'h10000;
    // ceil(2^17/3) and ceil(2^20/3): exact divide by 3 over the ranges used
    localparam logic [15:0] RECIP3_SEG = 16'd43691;
    localparam logic [18:0] RECIP3_LOC = 19'd349526;

    localparam logic [2:0] DIMS_RESET = 3'd3;

    // commands from controller to datapath
    typedef struct packed {
        logic       capture;
        logic       ld_t;
        logic       ld_s;
        logic       ld_l;
        logic       ld_lm;
        logic       ld_w;
        logic       acc_clr;
        logic       rd_en;
        logic [1:0] rd_k;
        logic       mul_en;
        logic [1:0] mul_k;
        logic       acc_en;
        logic       fin_load;
    } cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic curve_ok;
        logic out_free;
    } sts_t;

endpackage

/* rtl/core/pcbez_ctrl.sv */
// Sequencer of the Bezier curve evaluator.
// Depends on pcbez_pkg.
module pcbez_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_eval,
    output logic              in_stall,
    input  pcbez_pkg::sts_t   sts,
    output pcbez_pkg::cmd_t   cmd
);

    typedef enum logic [2:0] {
        IDLE, SEG_T, SEG_S, LOC_L, PROD_LM, WGT, ACC, FIN
    } state_t;

    state_t     state_reg, state_next;
    logic [2:0] k_reg, k_next;
    logic       accept;

    assign in_stall = (state_reg != IDLE);
    assign accept   = in_valid && (state_reg == IDLE);

    always_comb
    begin
        state_next = state_reg;
        k_next     = k_reg;
        case (state_reg)
            IDLE:
            begin
                if (accept)
                begin
                    state_next = (in_eval && sts.curve_ok) ? SEG_T : FIN;
                end
            end
            SEG_T:   state_next = SEG_S;
            SEG_S:   state_next = LOC_L;
            LOC_L:   state_next = PROD_LM;
            PROD_LM: state_next = WGT;
            WGT:
            begin
                state_next = ACC;
                k_next     = 3'd0;
            end
            ACC:
            begin
                k_next = k_reg + 3'd1;
                if (k_reg == 3'd5)
                begin
                    state_next = FIN;
                end
            end
            FIN:
            begin
                if (sts.out_free)
                begin
                    state_next = IDLE;
                end
            end
            default: state_next = IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= IDLE;
            k_reg     <= 3'd0;
        end
        else
        begin
            state_reg <= state_next;
            k_reg     <= k_next;
        end
    end

    // point k is read into rd_reg, then multiplied into prod_reg, then added into acc_reg
    always_comb
    begin
        cmd          = '0;
        cmd.capture  = accept;
        cmd.ld_t     = (state_reg == SEG_T);
        cmd.ld_s     = (state_reg == SEG_S);
        cmd.ld_l     = (state_reg == LOC_L);
        cmd.ld_lm    = (state_reg == PROD_LM);
        cmd.ld_w     = (state_reg == WGT);
        cmd.acc_clr  = (state_reg == WGT);
        cmd.rd_en    = (state_reg == ACC) && (k_reg <= 3'd3);
        cmd.rd_k     = k_reg[1:0];
        cmd.mul_en   = (state_reg == ACC) && (k_reg >= 3'd1) && (k_reg <= 3'd4);
        cmd.mul_k    = 2'(k_reg - 3'd1);
        cmd.acc_en   = (state_reg == ACC) && (k_reg >= 3'd2);
        cmd.fin_load = (state_reg == FIN) && sts.out_free;
    end

endmodule

/* rtl/core/pcbez_dpath.sv */
// Datapath of the Bezier curve evaluator: point store, weights, sums, result register.
// Depends on pcbez_pkg.
module pcbez_dpath
#(
    parameter int MAX_POINTS = 64,
    parameter int MAX_DIMS   = 4
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  pcbez_pkg::in_item_t  in_data,
    input  logic                 cfg_we,
    input  logic [2:0]           cfg_wdata,
    input  pcbez_pkg::cmd_t      cmd,
    output pcbez_pkg::sts_t      sts,
    output logic                 out_valid,
    input  logic                 out_stall,
    output pcbez_pkg::out_item_t out_data
);

    localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CW = $clog2(MAX_POINTS + 1);
    localparam int TW = 17 + CW;
    localparam int XW = TW - 16;
    localparam int RW = MAX_DIMS * 32;

    logic [RW-1:0] mem [MAX_POINTS];

    logic [2:0]           dims_reg;
    logic [CW-1:0]        count_reg;
    logic [1:0]           mod3_reg;
    logic [1:0]           kind_reg;
    logic [16:0]          u_reg;
    logic [RW-1:0]        coords_reg;
    logic [TW-1:0]        t_reg;
    logic                 uone_reg;
    logic [CW-1:0]        s_reg;
    logic [16:0]          l_reg;
    logic [16:0]          m_reg;
    logic [33:0]          l2_reg;
    logic [33:0]          m2_reg;
    logic [33:0]          lm_reg;
    logic signed [31:0]   w_reg    [4];
    logic [RW-1:0]        rd_reg;
    logic signed [63:0]   prod_reg [MAX_DIMS];
    logic signed [65:0]   acc_reg  [MAX_DIMS];
    logic                 out_valid_reg;
    pcbez_pkg::out_item_t out_data_reg;

    logic signed [31:0] in_coord [4];
    logic               full;
    logic [XW-1:0]      seg_x;
    logic [XW+15:0]     seg_p;
    logic [CW-1:0]      seg_q;
    logic [TW-1:0]      wq_full;
    logic [38:0]        loc_p;
    logic [18:0]        loc_q;
    logic [16:0]        m_val;
    logic [52:0]        pb [4];
    logic signed [39:0] tb [4];
    logic signed [39:0] l2_s, m2_s, lq_s;
    logic signed [31:0] w_val [4];
    logic [2:0]         nd;
    logic signed [31:0] vals [4];
    logic               is_eval;

    assign in_coord[0] = in_data.coord_a;
    assign in_coord[1] = in_data.coord_b;
    assign in_coord[2] = in_data.coord_c;
    assign in_coord[3] = in_data.coord_d;

    assign full          = (count_reg >= CW'(MAX_POINTS));
    assign is_eval       = kind_reg[1];
    assign sts.curve_ok  = (count_reg >= CW'(4)) && (mod3_reg == 2'd1);
    assign sts.out_free  = !out_valid_reg || !out_stall;

    // segment start: floor(floor(t/2^16)/3)*3
    assign seg_x = t_reg[TW-1:16];
    assign seg_p = (XW+16)'(seg_x) * (XW+16)'(pcbez_pkg::RECIP3_SEG);
    assign seg_q = CW'(seg_p[XW+15:17]);

    // local parameter: (wq+1)/3
    assign wq_full = t_reg - (TW'(s_reg) << 16);
    assign loc_p   = (39'(wq_full[18:0]) + 39'd1) * 39'(pcbez_pkg::RECIP3_LOC);
    assign loc_q   = loc_p[38:20];
    assign m_val   = pcbez_pkg::ONE_Q16 - l_reg;

    // weights
    always_comb
    begin
        pb[0] = 53'(m2_reg) * 53'(m_reg);
        pb[1] = 53'(3) * (53'(lm_reg) * 53'(m_reg));
        pb[2] = 53'(3) * (53'(lm_reg) * 53'(l_reg));
        pb[3] = 53'(l2_reg) * 53'(l_reg);
        l2_s  = signed'(40'(l2_reg));
        m2_s  = signed'(40'(m2_reg));
        lq_s  = signed'(40'({l_reg, 16'h0000}));
        tb[0] = -40'sd3 * m2_s;
        tb[1] = (40'sd3 <<< 32) - 40'sd12 * lq_s + 40'sd9 * l2_s;
        tb[2] = 40'sd6 * lq_s - 40'sd9 * l2_s;
        tb[3] = 40'sd3 * l2_s;
        for (int k = 0; k < 4; k++)
        begin
            if (kind_reg == pcbez_pkg::KIND_TANGENT)
            begin
                w_val[k] = 32'((tb[k] + 40'sd8) >>> 4);
            end
            else
            begin
                w_val[k] = signed'(32'((pb[k] + 53'd131072) >> 18));
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dims_reg      <= pcbez_pkg::DIMS_RESET;
            count_reg     <= '0;
            mod3_reg      <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                dims_reg <= cfg_wdata;
            end
            if (cmd.fin_load && kind_reg == pcbez_pkg::KIND_CLEAR)
            begin
                count_reg <= '0;
                mod3_reg  <= 2'd0;
            end
            else if (cmd.fin_load && kind_reg == pcbez_pkg::KIND_APPEND && !full)
            begin
                count_reg <= count_reg + CW'(1);
                mod3_reg  <= (mod3_reg == 2'd2) ? 2'd0 : mod3_reg + 2'd1;
            end
            if (cmd.fin_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // store write and registered read
    always_ff @(posedge clk)
    begin
        if (cmd.fin_load && kind_reg == pcbez_pkg::KIND_APPEND && !full)
        begin
            mem[AW'(count_reg)] <= coords_reg;
        end
        if (cmd.rd_en)
        begin
            rd_reg <= mem[AW'(s_reg + CW'(cmd.rd_k))];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            kind_reg <= in_data.kind;
            u_reg    <= (in_data.param_u > pcbez_pkg::ONE_Q16) ? pcbez_pkg::ONE_Q16
                                                                : in_data.param_u;
            for (int d = 0; d < MAX_DIMS; d++)
            begin
                coords_reg[d*32 +: 32] <= in_coord[d];
            end
        end
        if (cmd.ld_t)
        begin
            t_reg    <= TW'(u_reg) * TW'(count_reg - CW'(1));
            uone_reg <= (u_reg == pcbez_pkg::ONE_Q16);
        end
        if (cmd.ld_s)
        begin
            s_reg <= uone_reg ? count_reg - CW'(4) : seg_q + (seg_q << 1);
        end
        if (cmd.ld_l)
        begin
            l_reg <= (loc_q > 19'(pcbez_pkg::ONE_Q16)) ? pcbez_pkg::ONE_Q16 : loc_q[16:0];
        end
        if (cmd.ld_lm)
        begin
            l2_reg <= 34'(l_reg) * 34'(l_reg);
            m2_reg <= 34'(m_val) * 34'(m_val);
            lm_reg <= 34'(l_reg) * 34'(m_val);
            m_reg  <= m_val;
        end
        if (cmd.ld_w)
        begin
            for (int k = 0; k < 4; k++)
            begin
                w_reg[k] <= w_val[k];
            end
        end
        for (int d = 0; d < MAX_DIMS; d++)
        begin
            if (cmd.mul_en)
            begin
                prod_reg[d] <= signed'(rd_reg[d*32 +: 32]) * w_reg[cmd.mul_k];
            end
            if (cmd.acc_clr)
            begin
                acc_reg[d] <= '0;
            end
            else if (cmd.acc_en)
            begin
                acc_reg[d] <= acc_reg[d] + 66'(prod_reg[d]);
            end
        end
        if (cmd.fin_load)
        begin
            out_data_reg.value_a <= vals[0];
            out_data_reg.value_b <= vals[1];
            out_data_reg.value_c <= vals[2];
            out_data_reg.value_d <= vals[3];
            if (is_eval && !sts.curve_ok)
            begin
                out_data_reg.status <= pcbez_pkg::ST_INCOMPLETE;
            end
            else if (kind_reg == pcbez_pkg::KIND_APPEND && full)
            begin
                out_data_reg.status <= pcbez_pkg::ST_FULL;
            end
            else
            begin
                out_data_reg.status <= pcbez_pkg::ST_OK;
            end
        end
    end

    // dimension count in effect
    always_comb
    begin
        if (dims_reg == 3'd0)
        begin
            nd = 3'd1;
        end
        else if (dims_reg > 3'(MAX_DIMS))
        begin
            nd = 3'(MAX_DIMS);
        end
        else
        begin
            nd = dims_reg;
        end
    end

    // round to Q16.16 and saturate; zero for non-evaluations, incomplete curves and dimensions beyond nd
    for (genvar d = 0; d < 4; d++)
    begin : g_val
        if (d < MAX_DIMS)
        begin : g_used
            logic signed [65:0] rnd;
            always_comb
            begin
                if (kind_reg == pcbez_pkg::KIND_TANGENT)
                begin
                    rnd = (acc_reg[d] + (66'sd1 <<< 27)) >>> 28;
                end
                else
                begin
                    rnd = (acc_reg[d] + (66'sd1 <<< 29)) >>> 30;
                end
                if (!is_eval || !sts.curve_ok || 3'(d) >= nd)
                begin
                    vals[d] = '0;
                end
                else if (rnd > 66'sd2147483647)
                begin
                    vals[d] = 32'sh7FFFFFFF;
                end
                else if (rnd < -66'sd2147483648)
                begin
                    vals[d] = 32'sh80000000;
                end
                else
                begin
                    vals[d] = 32'(rnd);
                end
            end
        end
        else
        begin : g_unused
            assign vals[d] = '0;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

/* rtl/core/piecewise_cubic_bezier_curve_eval.sv */
// Piecewise cubic Bezier evaluator: holds up to MAX_POINTS control points of
// MAX_DIMS signed Q16.16 coordinates and answers each beat with one result.
// Append, clear and an evaluation refused as incomplete go from IDLE straight to FIN;
// an evaluation of a complete curve first runs a multiplier chain for segment, local
// parameter and weights, then four store reads, one point per cycle with all
// coordinates multiplied in parallel. One item is in work at a time;
// a result may wait in the output register while the next beat is taken.
// Depends on pcbez_pkg, pcbez_ctrl, pcbez_dpath.
module piecewise_cubic_bezier_curve_eval
#(
    parameter int MAX_POINTS = 64,
    parameter int MAX_DIMS   = 4
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  pcbez_pkg::in_item_t  in_data,
    output logic                 out_valid,
    input  logic                 out_stall,
    output pcbez_pkg::out_item_t out_data,
    input  logic                 cfg_we,
    input  logic [2:0]           cfg_wdata
);

    pcbez_pkg::cmd_t cmd;
    pcbez_pkg::sts_t sts;

    pcbez_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_eval  (in_data.kind[1]),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    pcbez_dpath
    #(
        .MAX_POINTS (MAX_POINTS),
        .MAX_DIMS   (MAX_DIMS)
    )
    u_dpath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .sts       (sts),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

/* rtl/core/pcbez_chk.sv */
// Port checker for the Bezier curve evaluator, bound to the top level.
// Depends on pcbez_pkg and assert_macros.svh.
`include "assert_macros.svh"

module pcbez_chk
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 in_valid,
    input logic                 in_stall,
    input logic                 out_valid,
    input logic                 out_stall,
    input pcbez_pkg::out_item_t out_data
)
;
    `AST_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_data))
    `AST_NEXT(a_busy_after_beat, clk, rst_n, in_valid && !in_stall, in_stall)
    `AST_SAME(a_status_code, clk, rst_n, out_valid, out_data.status != 2'd3)
    `AST_SAME(a_refused_zero, clk, rst_n, out_valid && out_data.status != pcbez_pkg::ST_OK, out_data.value_a == 0 && out_data.value_b == 0 && out_data.value_c == 0 && out_data.value_d == 0)

endmodule

bind piecewise_cubic_bezier_curve_eval pcbez_chk u_chk
(
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);
